// ===== hw/rtl/c3dc_pkg.sv =====
// Shared types and constants of the 3x3 convolution block.
package c3dc_pkg;

    localparam int unsigned PIX_W = 8;
    localparam int unsigned CNT_W = 11;
    localparam int unsigned SUM_W = 20;
    localparam int unsigned DIV_W = 8;
    localparam int unsigned MAX_HEIGHT = 1024;
    localparam logic [7:0] PIXEL_MAX = 8'd255;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_TOP    = 3'd2,
        REG_MIDDLE = 3'd3,
        REG_BOTTOM = 3'd4,
        REG_DIV    = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_DONE
    } div_state_t;

    // One classified job handed from the front to the back.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } job_t;

endpackage

// ===== hw/rtl/c3dc_front.sv =====
// Front part: line stores, window, counters and the weighted sum.
module c3dc_front #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [c3dc_pkg::PIX_W-1:0]    pixel_in,
    input  logic [c3dc_pkg::CNT_W-1:0]    width_lim,
    input  logic [c3dc_pkg::CNT_W-1:0]    height_lim,
    input  logic [23:0]                   coeff_top,
    input  logic [23:0]                   coeff_mid,
    input  logic [23:0]                   coeff_bot,
    output logic                          job_valid,
    input  logic                          job_ready,
    output c3dc_pkg::job_t                job
);
    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

    logic [c3dc_pkg::PIX_W-1:0] top_mem [MAX_WIDTH];
    logic [c3dc_pkg::PIX_W-1:0] mid_mem [MAX_WIDTH];

    // Stage 1: memory read, pixel held.
    logic                       s1_valid_reg;
    logic [c3dc_pkg::PIX_W-1:0] s1_bot_reg;
    logic [c3dc_pkg::PIX_W-1:0] s1_top_reg, s1_mid_reg;
    logic                       s1_prod_reg, s1_last_reg;
    logic [CW-1:0]              col_reg, col_next;
    logic [c3dc_pkg::CNT_W-1:0] row_reg, row_next;

    // Stage 2: products registered.
    logic                       s2_valid_reg;
    logic signed [16:0]         prod_reg [9];
    logic                       s2_last_reg;

    logic [c3dc_pkg::PIX_W-1:0] win_reg [6];

    logic s2_ready, s1_ready, accept;
    logic [AW-1:0] addr;

    assign s2_ready = !s2_valid_reg || job_ready;
    assign s1_ready = !s1_valid_reg || !s1_prod_reg || s2_ready;
    assign in_ready = s1_ready;
    assign accept   = in_valid && in_ready;
    assign addr     = col_reg[AW-1:0];

    always_comb
    begin
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if ({{(32-CW){1'b0}}, col_next} >= 32'(width_lim))
        begin
            col_next = '0;
            row_next = row_reg + c3dc_pkg::CNT_W'(1);
            if (row_next >= height_lim)
            begin
                row_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_mem[addr] <= mid_mem[addr];
            mid_mem[addr] <= pixel_in;
            s1_top_reg    <= top_mem[addr];
            s1_mid_reg    <= mid_mem[addr];
            s1_bot_reg    <= pixel_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_prod_reg  <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                s1_prod_reg  <= (row_reg >= c3dc_pkg::CNT_W'(2)) && (col_reg >= CW'(2));
                s1_last_reg  <= (32'(row_reg) + 1 >= 32'(height_lim))
                                && (32'(col_reg) + 1 >= 32'(width_lim));
                s1_valid_reg <= 1'b1;
            end
            else if (s1_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // The window shifts when stage 1 hands its pixel on.
    logic s1_fire;
    assign s1_fire = s1_valid_reg && s1_ready;

    logic [c3dc_pkg::PIX_W-1:0] px [9];
    always_comb
    begin
        px[0] = win_reg[0]; px[1] = win_reg[3]; px[2] = s1_top_reg;
        px[3] = win_reg[1]; px[4] = win_reg[4]; px[5] = s1_mid_reg;
        px[6] = win_reg[2]; px[7] = win_reg[5]; px[8] = s1_bot_reg;
    end

    logic signed [7:0] cf [9];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cf[k]     = coeff_top[8*k +: 8];
            cf[3 + k] = coeff_mid[8*k +: 8];
            cf[6 + k] = coeff_bot[8*k +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= s1_top_reg;
                win_reg[4] <= s1_mid_reg;
                win_reg[5] <= s1_bot_reg;
            end
            if (s1_fire && s1_prod_reg)
            begin
                s2_valid_reg <= 1'b1;
                s2_last_reg  <= s1_last_reg;
            end
            else if (job_ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_prod_reg)
        begin
            for (int i = 0; i < 9; i++)
            begin
                prod_reg[i] <= $signed({1'b0, px[i]}) * cf[i];
            end
        end
    end

    always_comb
    begin
        job.sum = '0;
        for (int i = 0; i < 9; i++)
        begin
            job.sum = job.sum + c3dc_pkg::SUM_W'(prod_reg[i]);
        end
        job.last = s2_last_reg;
    end
    assign job_valid = s2_valid_reg;

    stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !job_ready |=> s2_valid_reg)
        else $error("job dropped under stall");
    col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) <= MAX_WIDTH)
        else $error("column count out of range");
    prod_only_interior: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (col_reg < CW'(2)) |=> !s1_prod_reg)
        else $error("border pixel classified as interior");
endmodule

// ===== hw/rtl/c3dc_queue.sv =====
// Two-entry queue between the front and the back.
module c3dc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  c3dc_pkg::job_t  wr_job,
    output logic            rd_valid,
    input  logic            rd_ready,
    output c3dc_pkg::job_t  rd_job
);
    c3dc_pkg::job_t mem_reg [2];
    logic [1:0] wp_reg, rp_reg;
    logic [1:0] cnt;

    assign cnt      = wp_reg - rp_reg;
    assign wr_ready = cnt != 2'd2;
    assign rd_valid = cnt != 2'd0;
    assign rd_job   = mem_reg[rp_reg[0]];

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
        begin
            mem_reg[wp_reg[0]] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (wr_valid && wr_ready) wp_reg <= wp_reg + 2'd1;
            if (rd_valid && rd_ready) rp_reg <= rp_reg + 2'd1;
        end
    end

    fill_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt <= 2'd2)
        else $error("queue overfilled");
    no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cnt == 2'd2 && !rd_ready |=> cnt == 2'd2)
        else $error("queue level changed while full and stalled");
    empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
        cnt == 2'd0 && !wr_valid |=> cnt == 2'd0)
        else $error("queue filled without a write");
endmodule

// ===== hw/rtl/c3dc_back.sv =====
// Back part: signed restoring division, clamp and output register.
module c3dc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  c3dc_pkg::job_t                job,
    input  logic [c3dc_pkg::DIV_W-1:0]    divisor,
    output logic                          valid,
    input  logic                          ready,
    output logic [c3dc_pkg::PIX_W-1:0]    pixel_out,
    output logic                          last_of_plane
);
    localparam int unsigned MW = c3dc_pkg::SUM_W - 1;

    c3dc_pkg::div_state_t state_reg, state_next;
    logic [MW-1:0]  quo_reg, quo_next;
    logic [c3dc_pkg::DIV_W:0] rem_reg, rem_next;
    logic [4:0]     step_reg, step_next;
    logic           neg_reg, last_reg;
    logic [c3dc_pkg::DIV_W:0] trial;
    logic [c3dc_pkg::DIV_W-1:0] dv;
    logic [MW-1:0] mag;
    logic out_ok;

    assign dv = (divisor == '0) ? c3dc_pkg::DIV_W'(1) : divisor;
    assign mag = job.sum[c3dc_pkg::SUM_W-1] ? MW'(-job.sum) : MW'(job.sum);
    assign out_ok = !valid || ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            c3dc_pkg::DV_IDLE: if (job_valid) state_next = c3dc_pkg::DV_RUN;
            c3dc_pkg::DV_RUN:  if (step_reg == 5'(MW - 1)) state_next = c3dc_pkg::DV_DONE;
            c3dc_pkg::DV_DONE: if (out_ok) state_next = c3dc_pkg::DV_IDLE;
            default:           state_next = c3dc_pkg::DV_IDLE;
        endcase
    end

    assign job_ready = state_reg == c3dc_pkg::DV_IDLE;

    // One quotient bit per cycle, most significant first.
    always_comb
    begin
        trial     = {rem_reg[c3dc_pkg::DIV_W-1:0], quo_reg[MW-1]};
        rem_next  = trial;
        quo_next  = {quo_reg[MW-2:0], 1'b0};
        step_next = step_reg + 5'd1;
        if (trial >= {1'b0, dv})
        begin
            rem_next    = trial - {1'b0, dv};
            quo_next[0] = 1'b1;
        end
    end

    logic [7:0] clamped;
    always_comb
    begin
        priority if (neg_reg && quo_reg != '0) clamped = '0;
        else if (quo_reg > MW'(c3dc_pkg::PIXEL_MAX)) clamped = c3dc_pkg::PIXEL_MAX;
        else clamped = quo_reg[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= c3dc_pkg::DV_IDLE;
            valid     <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == c3dc_pkg::DV_IDLE && job_valid) step_reg <= '0;
            else if (state_reg == c3dc_pkg::DV_RUN) step_reg <= step_next;
            if (state_reg == c3dc_pkg::DV_DONE && out_ok) valid <= 1'b1;
            else if (ready) valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == c3dc_pkg::DV_IDLE && job_valid)
        begin
            quo_reg  <= mag;
            rem_reg  <= '0;
            neg_reg  <= job.sum[c3dc_pkg::SUM_W-1];
            last_reg <= job.last;
        end
        else if (state_reg == c3dc_pkg::DV_RUN)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (state_reg == c3dc_pkg::DV_DONE && out_ok)
        begin
            pixel_out     <= clamped;
            last_of_plane <= last_reg;
        end
    end

    run_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == c3dc_pkg::DV_RUN |-> step_reg < 5'(MW))
        else $error("division ran too long");
    take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_ready |-> state_reg == c3dc_pkg::DV_IDLE)
        else $error("job taken while busy");
    out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(pixel_out))
        else $error("result lost under stall");
endmodule

// ===== hw/rtl/conv3x3_divide_clamp.sv =====
// Top level of the streaming 3x3 convolution with divide and clamp.
// Front: one pixel per cycle, unless stalled, through line stores, window and products.
// Back: a 19-step restoring divider takes no new job until the previous result
// is in the output register; border pixels pass at one per cycle unless stalled.
// A window's result passes stage 1, product registers, queue, divider and output register.
// Reset clears counters, window and valid flags and presets configuration, not line stores.
module conv3x3_divide_clamp #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pixel_out,
    output logic        last_of_plane
);
    logic [10:0] width_reg, height_reg, width_lim, height_lim;
    logic [23:0] top_reg, mid_reg, bot_reg;
    logic [7:0]  div_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 11'd1024;
            top_reg    <= '0;
            mid_reg    <= 24'd256;
            bot_reg    <= '0;
            div_reg    <= 8'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                c3dc_pkg::REG_WIDTH:  width_reg  <= cfg_data[10:0];
                c3dc_pkg::REG_HEIGHT: height_reg <= cfg_data[10:0];
                c3dc_pkg::REG_TOP:    top_reg    <= cfg_data;
                c3dc_pkg::REG_MIDDLE: mid_reg    <= cfg_data;
                c3dc_pkg::REG_BOTTOM: bot_reg    <= cfg_data;
                c3dc_pkg::REG_DIV:    div_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        priority if (width_reg < 11'd3) width_lim = 11'd3;
        else if (32'(width_reg) > MAX_WIDTH) width_lim = 11'(MAX_WIDTH);
        else width_lim = width_reg;
        priority if (height_reg < 11'd3) height_lim = 11'd3;
        else if (32'(height_reg) > c3dc_pkg::MAX_HEIGHT) height_lim = 11'(c3dc_pkg::MAX_HEIGHT);
        else height_lim = height_reg;
    end

    logic f_valid, f_ready, b_valid, b_ready;
    c3dc_pkg::job_t f_job, b_job;

    c3dc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .pixel_in,
        .width_lim, .height_lim,
        .coeff_top(top_reg), .coeff_mid(mid_reg), .coeff_bot(bot_reg),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    c3dc_queue u_queue (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
    );

    c3dc_back u_back (
        .clk, .rst_n,
        .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
        .divisor(div_reg),
        .valid(out_valid), .ready(out_ready),
        .pixel_out, .last_of_plane
    );
endmodule

// ===== test/tb_conv3x3_divide_clamp.sv =====
// Self-checking testbench of the streaming 3x3 convolution with divide and clamp.
module tb_conv3x3_divide_clamp;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LINE_MAX = 1024;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam longint unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned RANDOM_ITEMS = 520;

    typedef struct {
        logic [7:0] pixel;
        logic       last;
    } filtered_t;

    typedef struct {
        bit                    is_cfg;
        c3dc_pkg::reg_index_t  idx;
        logic [23:0]           data;
        logic [7:0]            pixel;
        bit                    typed;
        logic [7:0]            want_pixel;
        bit                    want_last;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  pixel_in = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  pixel_out;
    logic        last_of_plane;

    // Shadow of the block: registers, line stores, window and counters.
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [23:0] kernel_rows [3];
    logic [7:0]  divisor_reg;
    logic [7:0]  line_mem [2*LINE_MAX];
    logic [7:0]  window [6];
    int unsigned col_pos;
    int unsigned row_pos;

    filtered_t   pending_pixels [$];
    stim_row_t   directed_rows [$];
    int          errors = 0;
    int unsigned pixels_sent = 0;
    int unsigned results_seen = 0;
    int unsigned planes_done = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    longint unsigned cycles = 0;

    conv3x3_divide_clamp dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_in      (pixel_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_out     (pixel_out),
        .last_of_plane (last_of_plane)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int unsigned eff_width();
        if (width_reg < 3) return 3;
        if (width_reg > LINE_MAX) return LINE_MAX;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg < 3) return 3;
        if (height_reg > c3dc_pkg::MAX_HEIGHT) return c3dc_pkg::MAX_HEIGHT;
        return height_reg;
    endfunction

    task automatic shadow_reset();
        width_reg = 11'd1024;
        height_reg = 11'd1024;
        kernel_rows[0] = 24'd0;
        kernel_rows[1] = 24'd256;
        kernel_rows[2] = 24'd0;
        divisor_reg = 8'd1;
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (window[i]) window[i] = '0;
        col_pos = 0;
        row_pos = 0;
    endtask

    // Advances the shadow by one pixel and returns the filtered result, if any.
    task automatic convolve_pixel(input logic [7:0] bot, output bit produced,
                                  output filtered_t res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int          dv;
        int          sum;
        int          q;
        int          px [9];
        byte         cf;
        logic [7:0]  top;
        logic [7:0]  mid;
        w = eff_width();
        h = eff_height();
        dv = (divisor_reg == 0) ? 1 : int'(divisor_reg);
        c = col_pos % LINE_MAX;
        top = line_mem[c];
        mid = line_mem[LINE_MAX + c];
        line_mem[c] = mid;
        line_mem[LINE_MAX + c] = bot;
        produced = (row_pos >= 2) && (c >= 2);
        res.pixel = '0;
        res.last = 1'b0;
        if (produced)
        begin
            px[0] = window[0]; px[1] = window[3]; px[2] = top;
            px[3] = window[1]; px[4] = window[4]; px[5] = mid;
            px[6] = window[2]; px[7] = window[5]; px[8] = bot;
            sum = 0;
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    cf = kernel_rows[r][8*k +: 8];
                    sum += px[3*r + k] * int'(cf);
                end
            end
            q = sum / dv;
            if (q < 0) q = 0;
            if (q > 255) q = 255;
            res.pixel = q[7:0];
            res.last = (row_pos + 1 >= h) && (c + 1 >= w);
        end
        window[0] = window[3];
        window[1] = window[4];
        window[2] = window[5];
        window[3] = top;
        window[4] = mid;
        window[5] = bot;
        c++;
        if (c >= w)
        begin
            c = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
        col_pos = c;
    endtask

    // Waits until every expected result has come and the divider has drained.
    task automatic wait_idle();
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register beat; the configuration channel is then left quiet before the task returns.
    task automatic write_reg(input c3dc_pkg::reg_index_t idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            c3dc_pkg::REG_WIDTH:  width_reg = value[10:0];
            c3dc_pkg::REG_HEIGHT: height_reg = value[10:0];
            c3dc_pkg::REG_TOP:    kernel_rows[0] = value;
            c3dc_pkg::REG_MIDDLE: kernel_rows[1] = value;
            c3dc_pkg::REG_BOTTOM: kernel_rows[2] = value;
            c3dc_pkg::REG_DIV:    divisor_reg = value[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Sends one pixel beat; a typed expectation replaces the shadow's answer.
    task automatic send_pixel(input logic [7:0] value, input bit typed,
                              input filtered_t typed_res);
        int unsigned gap;
        bit          produced;
        filtered_t   res;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 60) gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        convolve_pixel(value, produced, res);
        if (produced) pending_pixels.push_back(typed ? typed_res : res);
        pixels_sent++;
        if (produced && res.last) planes_done++;
    endtask

    function automatic logic [7:0] random_pixel();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] random_kernel_row();
        logic [23:0] v;
        v = 24'($urandom);
        if ($urandom_range(1))
        begin
            for (int k = 0; k < 3; k++)
                v[8*k +: 8] = 8'($signed($urandom_range(8)) - 4);
        end
        return v;
    endfunction

    function automatic void add_cfg(c3dc_pkg::reg_index_t idx, logic [23:0] value);
        stim_row_t row;
        row = '{is_cfg: 1'b1, idx: idx, data: value, pixel: '0, typed: 1'b0,
                want_pixel: '0, want_last: 1'b0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_pix(logic [7:0] value, bit typed = 1'b0,
                                    logic [7:0] want = '0, bit want_last = 1'b0);
        stim_row_t row;
        row = '{is_cfg: 1'b0, idx: c3dc_pkg::REG_WIDTH, data: '0, pixel: value,
                typed: typed, want_pixel: want, want_last: want_last};
        directed_rows.push_back(row);
    endfunction

    task automatic set_idling(input int unsigned mode);
        case (mode % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 85; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 85; end
            default: begin sender_idle_pct = 13; receiver_stall_pct = 13; end
        endcase
    endtask

    task automatic run_plane(input logic [10:0] w, input logic [10:0] h,
                             input bit hold_midway);
        int unsigned n;
        filtered_t   none;
        none = '{pixel: '0, last: 1'b0};
        wait_idle();
        write_reg(c3dc_pkg::REG_WIDTH, 24'(w));
        write_reg(c3dc_pkg::REG_HEIGHT, 24'(h));
        write_reg(c3dc_pkg::REG_TOP, random_kernel_row());
        write_reg(c3dc_pkg::REG_MIDDLE, random_kernel_row());
        write_reg(c3dc_pkg::REG_BOTTOM, random_kernel_row());
        write_reg(c3dc_pkg::REG_DIV,
                  ($urandom_range(9) == 0) ? 24'd0 : 24'($urandom_range(255, 1)));
        n = eff_width() * eff_height();
        for (int unsigned i = 0; i < n; i++)
        begin
            if (hold_midway && i == n / 2)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_pixels.size() != 0);
            end
            send_pixel(random_pixel(), 1'b0, none);
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        filtered_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, pending_pixels.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected result beat: pixel_out %0d last_of_plane %0d",
                       pixel_out, last_of_plane);
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_out !== want.pixel)
                begin
                    $error("pixel_out: expected %0d, got %0d", want.pixel, pixel_out);
                    errors++;
                end
                if (last_of_plane !== want.last)
                begin
                    $error("last_of_plane: expected %0d, got %0d", want.last,
                           last_of_plane);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        filtered_t typed_res;
        int unsigned plane_no;
        shadow_reset();

        // Identity kernel on a 3x3 plane, with width, height and divisor out of range.
        add_cfg(c3dc_pkg::REG_WIDTH, 24'd2);
        add_cfg(c3dc_pkg::REG_HEIGHT, 24'd0);
        add_cfg(c3dc_pkg::REG_TOP, 24'h000000);
        add_cfg(c3dc_pkg::REG_MIDDLE, 24'h000100);
        add_cfg(c3dc_pkg::REG_BOTTOM, 24'h000000);
        add_cfg(c3dc_pkg::REG_DIV, 24'd0);
        add_pix(8'd0); add_pix(8'd255); add_pix(8'd0);
        add_pix(8'd255); add_pix(8'd128); add_pix(8'd255);
        add_pix(8'd0); add_pix(8'd255); add_pix(8'd1, 1'b1, 8'd128, 1'b1);
        // Largest positive weights clamp high even after the largest divisor.
        add_cfg(c3dc_pkg::REG_TOP, 24'h7f7f7f);
        add_cfg(c3dc_pkg::REG_MIDDLE, 24'h7f7f7f);
        add_cfg(c3dc_pkg::REG_BOTTOM, 24'h7f7f7f);
        add_cfg(c3dc_pkg::REG_DIV, 24'd255);
        for (int i = 0; i < 8; i++) add_pix(8'd255);
        add_pix(8'd255, 1'b1, 8'd255, 1'b1);
        // Most negative weights clamp low.
        add_cfg(c3dc_pkg::REG_TOP, 24'h808080);
        add_cfg(c3dc_pkg::REG_MIDDLE, 24'h808080);
        add_cfg(c3dc_pkg::REG_BOTTOM, 24'h808080);
        add_cfg(c3dc_pkg::REG_DIV, 24'd1);
        for (int i = 0; i < 8; i++) add_pix(8'd255);
        add_pix(8'd255, 1'b1, 8'd0, 1'b1);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                in_valid <= 1'b0;
                wait_idle();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
            begin
                typed_res = '{pixel: directed_rows[i].want_pixel,
                              last: directed_rows[i].want_last};
                send_pixel(directed_rows[i].pixel, directed_rows[i].typed, typed_res);
            end
        end

        plane_no = 0;
        while (pixels_sent < RANDOM_ITEMS)
        begin
            set_idling(plane_no);
            in_valid <= 1'b0;
            if ($urandom_range(4) == 0)
                run_plane(11'($urandom_range(2)), 11'($urandom_range(2)), plane_no == 0);
            else
                run_plane(11'($urandom_range(12, 3)), 11'($urandom_range(8, 3)),
                          plane_no == 0);
            plane_no++;
        end
        in_valid <= 1'b0;

        wait_idle();
        $display("Sent %0d pixels over %0d planes from 3x3 up to 12x8, sizes below",
                 pixels_sent, planes_done);
        $display("the minimum included; checked %0d filtered results under four idling patterns.",
                 results_seen);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
